>>> src/name_value_block_deframer_macros.svh
// ----------------------------------------------------------------------------
// name_value_block_deframer_macros.svh
// Assertion helpers shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef NAME_VALUE_BLOCK_DEFRAMER_MACROS_SVH
`define NAME_VALUE_BLOCK_DEFRAMER_MACROS_SVH

// Condition a on this edge implies condition c on the same edge.
`define NVBD_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Condition a on this edge implies condition c on the next edge.
`define NVBD_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> src/nvbd_pkg.sv
// ----------------------------------------------------------------------------
// nvbd_pkg
// Types shared by the name/value block deframer modules.
// ----------------------------------------------------------------------------
package nvbd_pkg;

  typedef enum logic [2:0] {
    PH_COUNT_HI    = 3'd0,
    PH_COUNT_LO    = 3'd1,
    PH_NAME_LEN_HI = 3'd2,
    PH_NAME_LEN_LO = 3'd3,
    PH_NAME_DATA   = 3'd4,
    PH_VAL_LEN_HI  = 3'd5,
    PH_VAL_LEN_LO  = 3'd6,
    PH_VAL_DATA    = 3'd7
  } phase_t;

  localparam logic FIELD_NAME  = 1'b0;
  localparam logic FIELD_VALUE = 1'b1;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        field_kind;
    logic        field_end;
    logic [15:0] pair_index;
    logic        block_end;
    logic        count_error;
  } res_t;

endpackage

>>> src/nvbd_front.sv
// ----------------------------------------------------------------------------
// nvbd_front
// Parser: walks the count / length / data layout one byte per accepted word
// and builds the result record for that byte.
// ----------------------------------------------------------------------------
module nvbd_front
  import nvbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] in_byte,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] pairs_left_r, pairs_left_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] cur_pair_r, cur_pair_nxt;

  logic [15:0] len_word;
  logic        len_zero;
  logic        last_byte;
  logic        last_pair;

  assign len_word  = {hold_r, in_byte};
  assign len_zero  = (len_word == 16'd0);
  assign last_byte = ((bytes_left_r - 16'd1) == 16'd0);
  assign last_pair = ((pairs_left_r - 16'd1) == 16'd0);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_COUNT_HI:    phase_nxt = PH_COUNT_LO;
      PH_COUNT_LO:    phase_nxt = len_zero ? PH_COUNT_HI : PH_NAME_LEN_HI;
      PH_NAME_LEN_HI: phase_nxt = PH_NAME_LEN_LO;
      PH_NAME_LEN_LO: phase_nxt = len_zero ? PH_VAL_LEN_HI : PH_NAME_DATA;
      PH_NAME_DATA:   phase_nxt = last_byte ? PH_VAL_LEN_HI : PH_NAME_DATA;
      PH_VAL_LEN_HI:  phase_nxt = PH_VAL_LEN_LO;
      PH_VAL_LEN_LO: begin
        if (!len_zero)      phase_nxt = PH_VAL_DATA;
        else if (last_pair) phase_nxt = PH_COUNT_HI;
        else                phase_nxt = PH_NAME_LEN_HI;
      end
      PH_VAL_DATA: begin
        if (!last_byte)     phase_nxt = PH_VAL_DATA;
        else if (last_pair) phase_nxt = PH_COUNT_HI;
        else                phase_nxt = PH_NAME_LEN_HI;
      end
      default:        phase_nxt = PH_COUNT_HI;
    endcase
  end

  // result for the current byte
  always_comb begin
    res              = '0;
    res.pair_index   = cur_pair_r;
    unique case (phase_r)
      PH_COUNT_HI:    res.pair_index = 16'd0;
      PH_COUNT_LO: begin
        res.pair_index  = 16'd0;
        res.count_error = len_zero;
      end
      PH_NAME_LEN_HI: res.field_kind = FIELD_NAME;
      PH_NAME_LEN_LO: res.field_end  = len_zero;
      PH_NAME_DATA: begin
        res.payload_byte = in_byte;
        res.is_payload   = 1'b1;
        res.field_end    = last_byte;
      end
      PH_VAL_LEN_HI:  res.field_kind = FIELD_VALUE;
      PH_VAL_LEN_LO: begin
        res.field_kind = FIELD_VALUE;
        res.field_end  = len_zero;
        res.block_end  = len_zero && last_pair;
      end
      PH_VAL_DATA: begin
        res.field_kind   = FIELD_VALUE;
        res.payload_byte = in_byte;
        res.is_payload   = 1'b1;
        res.field_end    = last_byte;
        res.block_end    = last_byte && last_pair;
      end
      default:        res = '0;
    endcase
  end

  // counters and length holding register
  always_comb begin
    pairs_left_nxt = pairs_left_r;
    bytes_left_nxt = bytes_left_r;
    hold_nxt       = hold_r;
    cur_pair_nxt   = cur_pair_r;
    unique case (phase_r)
      PH_COUNT_HI, PH_NAME_LEN_HI, PH_VAL_LEN_HI: hold_nxt = in_byte;
      PH_COUNT_LO: begin
        cur_pair_nxt   = 16'd0;
        pairs_left_nxt = len_word;
      end
      PH_NAME_LEN_LO: begin
        if (!len_zero) bytes_left_nxt = len_word;
      end
      PH_NAME_DATA:   bytes_left_nxt = bytes_left_r - 16'd1;
      PH_VAL_LEN_LO: begin
        if (!len_zero) begin
          bytes_left_nxt = len_word;
        end else begin
          pairs_left_nxt = pairs_left_r - 16'd1;
          if (!last_pair) cur_pair_nxt = cur_pair_r + 16'd1;
        end
      end
      PH_VAL_DATA: begin
        bytes_left_nxt = bytes_left_r - 16'd1;
        if (last_byte) begin
          pairs_left_nxt = pairs_left_r - 16'd1;
          if (!last_pair) cur_pair_nxt = cur_pair_r + 16'd1;
        end
      end
      default: hold_nxt = hold_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT_HI;
      pairs_left_r <= 16'd0;
      bytes_left_r <= 16'd0;
      hold_r       <= 8'd0;
      cur_pair_r   <= 16'd0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      pairs_left_r <= pairs_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      hold_r       <= hold_nxt;
      cur_pair_r   <= cur_pair_nxt;
    end
  end

endmodule

>>> src/nvbd_queue.sv
// ----------------------------------------------------------------------------
// nvbd_queue
// Small result queue between the parser and the output side; the head entry
// drives the result ports.
// ----------------------------------------------------------------------------
module nvbd_queue
  import nvbd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_data,
  input  logic rd_en,
  output res_t rd_data,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      if (do_rd) rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      if (do_wr && !do_rd)      cnt_r <= cnt_r + CW'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

>>> src/name_value_block_deframer.sv
// ----------------------------------------------------------------------------
// name_value_block_deframer
// Header block deframer: one classified result word per input byte.
// ----------------------------------------------------------------------------
// Input: push in_byte while in_full is low; one byte per cycle is taken.
// Output: while out_empty is low the oldest result sits on the out_ ports;
// pop takes it. Every accepted byte yields exactly one result.
// Visibility: a byte accepted at an edge while the queue is empty is visible on
// the out_ ports just after that edge. Throughput: one byte per cycle while
// in_full is low, each byte taking one parser state update.
// The parser writes results into a DEPTH-entry queue; when the receiver stops
// popping, the queue fills and in_full rises after DEPTH unread results, and
// input resumes the cycle after a pop frees an entry.
// Reset (synchronous, rst_n low): queue emptied, parser waits for the high
// byte of a new pair count. A zero count flags out_count_error and the next
// byte starts a new count; after out_block_end the same happens.
// ----------------------------------------------------------------------------
`include "name_value_block_deframer_macros.svh"

module name_value_block_deframer
  import nvbd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_byte,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_payload,
  output logic        out_field_kind,
  output logic        out_field_end,
  output logic [15:0] out_pair_index,
  output logic        out_block_end,
  output logic        out_count_error
);

  logic take;
  res_t front_res;
  res_t head;

  assign take = in_push && !in_full;

  nvbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .res     (front_res)
  );

  nvbd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (take),
    .wr_data (front_res),
    .rd_en   (out_pop),
    .rd_data (head),
    .full    (in_full),
    .empty   (out_empty)
  );

  assign out_payload_byte = head.payload_byte;
  assign out_is_payload   = head.is_payload;
  assign out_field_kind   = head.field_kind;
  assign out_field_end    = head.field_end;
  assign out_pair_index   = head.pair_index;
  assign out_block_end    = head.block_end;
  assign out_count_error  = head.count_error;

  `NVBD_ASSERT_NEXT(a_take_shows, take && out_empty, !out_empty, "accepted word not visible")
  `NVBD_ASSERT_NOW(a_full_empty, in_full, !out_empty, "queue full and empty at once")
  `NVBD_ASSERT_NOW(a_bend_fend, !out_empty && out_block_end, out_field_end && out_field_kind, "block end without value field end")
  `NVBD_ASSERT_NOW(a_cerr_clean, !out_empty && out_count_error, !out_is_payload && !out_block_end && out_pair_index == 16'd0, "count error word malformed")

endmodule

>>> bench/name_value_block_deframer_test.sv
// ----------------------------------------------------------------------------
// name_value_block_deframer_test
// Self-checking bench for the name/value header block deframer.
// ----------------------------------------------------------------------------
// Bytes go in through the push/full queue port. Each accepted byte runs
// through a local parser model, and its classified word is queued. Every word
// popped from the block is compared field by field with the oldest queued
// word. A short table of hand-built blocks comes first. Random traffic
// follows: mostly well-formed blocks, some zero counts, some truncated
// blocks and some junk bytes, each followed by a resync. The run ends on a
// block with maximum count and length. Both ports stall in random bursts.
// ----------------------------------------------------------------------------
module name_value_block_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nvbd_pkg::*;

  logic        clk;
  logic        rst_n   = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        in_full;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [7:0]  out_payload_byte;
  logic        out_is_payload;
  logic        out_field_kind;
  logic        out_field_end;
  logic [15:0] out_pair_index;
  logic        out_block_end;
  logic        out_count_error;

  name_value_block_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_byte          (in_byte),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_payload_byte (out_payload_byte),
    .out_is_payload   (out_is_payload),
    .out_field_kind   (out_field_kind),
    .out_field_end    (out_field_end),
    .out_pair_index   (out_pair_index),
    .out_block_end    (out_block_end),
    .out_count_error  (out_count_error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TIMEOUT: results still pending");
    $display("name_value_block_deframer test failed");
    $finish;
  end

  // ---------------- parser model ----------------
  phase_t      ph        = PH_COUNT_HI;
  logic [15:0] pairs_rem = '0;
  logic [15:0] field_rem = '0;
  logic [7:0]  hi_hold   = '0;
  logic [15:0] pair_no   = '0;

  // Value field done: step to the next pair, or close the block.
  function automatic logic close_pair();
    pairs_rem = pairs_rem - 16'd1;
    if (pairs_rem == 16'd0) begin
      ph = PH_COUNT_HI;
      return 1'b1;
    end
    pair_no = pair_no + 16'd1;
    ph = PH_NAME_LEN_HI;
    return 1'b0;
  endfunction

  function automatic res_t deframe_byte(input logic [7:0] b);
    res_t        r;
    logic [15:0] len;
    len = {hi_hold, b};
    r = '0;
    r.field_kind = FIELD_NAME;
    r.pair_index = pair_no;
    case (ph)
      PH_COUNT_HI: begin
        hi_hold = b;
        r.pair_index = '0;
        ph = PH_COUNT_LO;
      end
      PH_COUNT_LO: begin
        r.pair_index = '0;
        pair_no = '0;
        if (len == 16'd0) begin
          r.count_error = 1'b1;
          pairs_rem = '0;
          ph = PH_COUNT_HI;
        end else begin
          pairs_rem = len;
          ph = PH_NAME_LEN_HI;
        end
      end
      PH_NAME_LEN_HI: begin
        hi_hold = b;
        ph = PH_NAME_LEN_LO;
      end
      PH_NAME_LEN_LO: begin
        if (len == 16'd0) begin
          r.field_end = 1'b1;
          ph = PH_VAL_LEN_HI;
        end else begin
          field_rem = len;
          ph = PH_NAME_DATA;
        end
      end
      PH_NAME_DATA: begin
        r.payload_byte = b;
        r.is_payload = 1'b1;
        field_rem = field_rem - 16'd1;
        if (field_rem == 16'd0) begin
          r.field_end = 1'b1;
          ph = PH_VAL_LEN_HI;
        end
      end
      PH_VAL_LEN_HI: begin
        r.field_kind = FIELD_VALUE;
        hi_hold = b;
        ph = PH_VAL_LEN_LO;
      end
      PH_VAL_LEN_LO: begin
        r.field_kind = FIELD_VALUE;
        if (len == 16'd0) begin
          r.field_end = 1'b1;
          r.block_end = close_pair();
        end else begin
          field_rem = len;
          ph = PH_VAL_DATA;
        end
      end
      default: begin
        r.field_kind = FIELD_VALUE;
        r.payload_byte = b;
        r.is_payload = 1'b1;
        field_rem = field_rem - 16'd1;
        if (field_rem == 16'd0) begin
          r.field_end = 1'b1;
          r.block_end = close_pair();
        end
      end
    endcase
    return r;
  endfunction

  // ---------------- scoreboard ----------------
  res_t pending_words[$];
  int   errors        = 0;
  int   words_checked = 0;
  int   bytes_sent    = 0;
  int   blocks_closed = 0;
  int   zero_counts   = 0;
  bit   idle_on       = 1'b0;
  int   pop_hold      = 0;

  task automatic report_bad(input string what, input logic [15:0] got,
                            input logic [15:0] want);
    $display("MISMATCH word %0d %s: got %h expected %h", words_checked, what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      out_pop  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      pop_hold <= $urandom_range(0, 11);
      out_pop  <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_words.size() == 0) begin
        report_bad("unexpected word", {8'h00, out_payload_byte}, 16'h0000);
      end else begin
        want = pending_words.pop_front();
        if (out_payload_byte !== want.payload_byte)
          report_bad("payload_byte", {8'h00, out_payload_byte}, {8'h00, want.payload_byte});
        if (out_is_payload !== want.is_payload)
          report_bad("is_payload", {15'd0, out_is_payload}, {15'd0, want.is_payload});
        if (out_field_kind !== want.field_kind)
          report_bad("field_kind", {15'd0, out_field_kind}, {15'd0, want.field_kind});
        if (out_field_end !== want.field_end)
          report_bad("field_end", {15'd0, out_field_end}, {15'd0, want.field_end});
        if (out_pair_index !== want.pair_index)
          report_bad("pair_index", out_pair_index, want.pair_index);
        if (out_block_end !== want.block_end)
          report_bad("block_end", {15'd0, out_block_end}, {15'd0, want.block_end});
        if (out_count_error !== want.count_error)
          report_bad("count_error", {15'd0, out_count_error}, {15'd0, want.count_error});
      end
      words_checked++;
    end
  end

  // ---------------- stimulus ----------------
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t typed_word);
    res_t r;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    r = deframe_byte(b);
    pending_words.push_back(typed ? typed_word : r);
    bytes_sent++;
    if (r.block_end) blocks_closed++;
    if (r.count_error) zero_counts++;
    @(negedge clk);
  endtask

  logic [7:0] frame_bytes[$];

  function automatic logic [15:0] pick_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return 16'd0;
    if (sel < 80) return 16'($urandom_range(1, 6));
    if (sel < 96) return 16'($urandom_range(7, 20));
    return 16'($urandom_range(256, 300));
  endfunction

  task automatic build_block();
    logic [15:0] cnt;
    logic [15:0] len;
    frame_bytes.delete();
    cnt = 16'($urandom_range(1, 4));
    frame_bytes.push_back(cnt[15:8]);
    frame_bytes.push_back(cnt[7:0]);
    repeat (cnt) begin
      repeat (2) begin
        len = pick_len();
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        repeat (len) frame_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // Junk that cannot open a huge count or length, so resync stays short.
  function automatic logic [7:0] junk_byte();
    if (ph inside {PH_COUNT_HI, PH_NAME_LEN_HI, PH_VAL_LEN_HI}) return 8'h00;
    if (ph == PH_COUNT_LO) return 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  // Feed filler until the parser waits for a new count again.
  task automatic resync();
    while (ph != PH_COUNT_HI)
      send_byte((ph inside {PH_NAME_DATA, PH_VAL_DATA}) ? 8'($urandom) : 8'h00, 1'b0, '0);
  endtask

  typedef struct {
    logic [7:0] b;
    bit         typed;
    res_t       want;
  } plan_row_t;

  plan_row_t plan [22];

  initial begin
    int sel;
    int cut;
    plan = '{
      // zero count after reset
      '{8'h00, 1'b1, res_t'{8'h00, 1'b0, FIELD_NAME, 1'b0, 16'd0, 1'b0, 1'b0}},
      '{8'h00, 1'b1, res_t'{8'h00, 1'b0, FIELD_NAME, 1'b0, 16'd0, 1'b0, 1'b1}},
      // one pair, empty name and empty value
      '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, res_t'{8'h00, 1'b0, FIELD_NAME, 1'b1, 16'd0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, res_t'{8'h00, 1'b0, FIELD_VALUE, 1'b1, 16'd0, 1'b1, 1'b0}},
      // two pairs with payload
      '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
      '{8'hFF, 1'b1, res_t'{8'hFF, 1'b1, FIELD_NAME, 1'b1, 16'd0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'hA5, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
      '{8'h7E, 1'b1, res_t'{8'h7E, 1'b1, FIELD_VALUE, 1'b1, 16'd1, 1'b1, 1'b0}}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) send_byte(plan[i].b, plan[i].typed, plan[i].want);

    while (bytes_sent < 1800) begin
      idle_on = (bytes_sent < 1550) && ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        send_byte(8'h00, 1'b0, '0);
        send_byte(8'h00, 1'b0, '0);
      end else if (sel < 16) begin
        // truncated block
        build_block();
        cut = $urandom_range(1, frame_bytes.size() - 1);
        for (int i = 0; i < cut; i++) send_byte(frame_bytes[i], 1'b0, '0);
        resync();
      end else if (sel < 24) begin
        repeat ($urandom_range(1, 10)) send_byte(junk_byte(), 1'b0, '0);
        resync();
      end else begin
        build_block();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, '0);
      end
    end

    // maximum count and value length; left open at the end of the run
    idle_on = 1'b0;
    send_byte(8'hFF, 1'b0, '0);
    send_byte(8'hFF, 1'b0, '0);
    send_byte(8'h00, 1'b0, '0);
    send_byte(8'h01, 1'b0, '0);
    send_byte(8'($urandom), 1'b0, '0);
    send_byte(8'hFF, 1'b0, '0);
    send_byte(8'hFF, 1'b0, '0);
    repeat (12) send_byte(8'($urandom), 1'b0, '0);
    in_push <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes, checked %0d words: %0d blocks closed, %0d zero counts.",
             bytes_sent, words_checked, blocks_closed, zero_counts);
    $display("Covered empty fields, long fields, truncated blocks, junk and max count.");
    if (errors == 0) begin
      $display("name_value_block_deframer test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("name_value_block_deframer test failed");
    end
    $finish;
  end

endmodule
